### design/bfa_pkg.sv
// shared types, constants and helper function of the bitmap frame allocator
`default_nettype none

package bfa_pkg;

  // parameter defaults
  localparam int unsigned FramesDef    = 32768;
  localparam int unsigned PageShiftDef = 12;

  // register reset values
  localparam logic [31:0] BaseAddressRst = 32'h0010_0000;
  localparam logic [15:0] FrameCountRst  = 16'd32768;

  // request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // register indexes
  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_FRAME_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OOM         = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_INVALID     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE_IDX,
    S_FREE_CHK,
    S_SCAN,
    S_HIT
  } state_e;

  typedef struct packed {
    logic [31:0] base_address;
    logic [15:0] frame_count;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic    load_free;
    logic    scan_start;
    logic    scan_rd;
    logic    free_rd;
    logic    free_commit;
    logic    alloc_commit;
    logic    fin;
    status_e fin_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic free_in_range;
    logic free_bit_set;
    logic word_ready;
    logic word_has_free;
    logic word_past_lim;
    logic word_last;
    logic hit_in_range;
  } stat_t;

  // position of the lowest clear bit, zero when none
  function automatic logic [4:0] first_zero(input logic [31:0] word);
    logic [4:0] pos;
    pos = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (!word[i]) pos = 5'(i);
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

### design/bitmap_frame_allocator_top.sv
// top level of the bitmap page frame allocator, first fit
`default_nettype none

// sequence: a free ends after the range check when out of range, else after a bitmap word check;
// an allocate reads the bitmap at one 32-frame word per cycle until a word with a free bit, which
// then passes the hit state, or until the frame limit or the last word; done_o is registered
// throughput: one transaction at a time, the next start is taken the cycle done_o shows
// reset: asynchronous, all frames free, count zero, registers at their reset values;
// the bitmap needs no clearing pass, a fill mark treats unwritten words as free
module bitmap_frame_allocator_top #(
  parameter int unsigned FRAMES     = bfa_pkg::FramesDef,
  parameter int unsigned PAGE_SHIFT = bfa_pkg::PageShiftDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // request side
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation_i,
  input  wire logic [31:0] free_address_i,
  // result side, one cycle strobe, no back pressure
  output logic             done_o,
  output logic      [31:0] frame_address_o,
  output logic      [1:0]  status_o,
  output logic      [15:0] frames_in_use_o
);

  bfa_pkg::cfg_t  cfg;
  bfa_pkg::cmd_t  cmd;
  bfa_pkg::stat_t stat;

  // base address and frame count
  bfa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer: free path checks range then one bitmap word,
  // allocate path scans words until a free bit, the frame limit or the last word
  bfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .busy        (busy),
    .cmd_o       (cmd)
  );

  // bitmap memory, index math, used count and result registers
  bfa_dpath #(
    .FRAMES     (FRAMES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .free_address_i  (free_address_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .done_o          (done_o),
    .frame_address_o (frame_address_o),
    .status_o        (status_o),
    .frames_in_use_o (frames_in_use_o)
  );

endmodule

`default_nettype wire

### design/bfa_regs.sv
// apb configuration registers of the frame allocator
`default_nettype none

module bfa_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output bfa_pkg::cfg_t      cfg_o
);

  logic [31:0] base_address_q;
  logic [15:0] frame_count_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= bfa_pkg::BaseAddressRst;
      frame_count_q  <= bfa_pkg::FrameCountRst;
    end else if (wr_en) begin
      unique case (paddr[2])
        bfa_pkg::REG_BASE_ADDRESS: base_address_q <= pwdata;
        bfa_pkg::REG_FRAME_COUNT:  frame_count_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      bfa_pkg::REG_BASE_ADDRESS: prdata = base_address_q;
      bfa_pkg::REG_FRAME_COUNT:  prdata = {16'd0, frame_count_q};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o.base_address = base_address_q;
  assign cfg_o.frame_count  = frame_count_q;

endmodule

`default_nettype wire

### design/bfa_ctrl.sv
// request sequencer of the frame allocator
`default_nettype none

module bfa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic           operation_i,
  input  wire bfa_pkg::stat_t stat_i,
  output logic                busy,
  output bfa_pkg::cmd_t       cmd_o
);

  bfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.fin_status = bfa_pkg::ST_OK;
    busy    = 1'b1;
    unique case (state_q)
      bfa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation_i == bfa_pkg::OP_FREE) begin
            cmd_o.load_free = 1'b1;
            state_d = bfa_pkg::S_FREE_IDX;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = bfa_pkg::S_SCAN;
          end
        end
      end
      bfa_pkg::S_FREE_IDX: begin
        if (stat_i.free_in_range) begin
          cmd_o.free_rd = 1'b1;
          state_d = bfa_pkg::S_FREE_CHK;
        end else begin
          cmd_o.fin = 1'b1;
          cmd_o.fin_status = bfa_pkg::ST_INVALID;
          state_d = bfa_pkg::S_IDLE;
        end
      end
      bfa_pkg::S_FREE_CHK: begin
        cmd_o.fin = 1'b1;
        if (stat_i.free_bit_set) begin
          cmd_o.free_commit = 1'b1;
          cmd_o.fin_status = bfa_pkg::ST_OK;
        end else begin
          cmd_o.fin_status = bfa_pkg::ST_DOUBLE_FREE;
        end
        state_d = bfa_pkg::S_IDLE;
      end
      bfa_pkg::S_SCAN: begin
        if (stat_i.word_ready && stat_i.word_past_lim) begin
          cmd_o.fin = 1'b1;
          cmd_o.fin_status = bfa_pkg::ST_OOM;
          state_d = bfa_pkg::S_IDLE;
        end else if (stat_i.word_ready && stat_i.word_has_free) begin
          state_d = bfa_pkg::S_HIT;
        end else if (stat_i.word_ready && stat_i.word_last) begin
          cmd_o.fin = 1'b1;
          cmd_o.fin_status = bfa_pkg::ST_OOM;
          state_d = bfa_pkg::S_IDLE;
        end else begin
          cmd_o.scan_rd = 1'b1;
        end
      end
      bfa_pkg::S_HIT: begin
        cmd_o.fin = 1'b1;
        if (stat_i.hit_in_range) begin
          cmd_o.alloc_commit = 1'b1;
          cmd_o.fin_status = bfa_pkg::ST_OK;
        end else begin
          cmd_o.fin_status = bfa_pkg::ST_OOM;
        end
        state_d = bfa_pkg::S_IDLE;
      end
      default: state_d = bfa_pkg::S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

### design/bfa_dpath.sv
// bitmap memory, scan pointer, counters and result registers of the frame allocator
`default_nettype none

module bfa_dpath #(
  parameter int unsigned FRAMES     = bfa_pkg::FramesDef,
  parameter int unsigned PAGE_SHIFT = bfa_pkg::PageShiftDef
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bfa_pkg::cfg_t  cfg_i,
  input  wire logic [31:0]    free_address_i,
  input  wire bfa_pkg::cmd_t  cmd_i,
  output bfa_pkg::stat_t      stat_o,
  output logic                done_o,
  output logic      [31:0]    frame_address_o,
  output logic      [1:0]     status_o,
  output logic      [15:0]    frames_in_use_o
);

  localparam int unsigned WORDS = (FRAMES + 31) / 32;
  localparam int unsigned WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned FW    = $clog2(WORDS + 1);
  localparam logic [WA_W-1:0] LastWord = WA_W'(WORDS - 1);

  logic [31:0]     mem [WORDS];

  logic [WA_W-1:0] scan_addr_q, scan_addr_d;
  logic [WA_W-1:0] rd_addr, rd_addr_q;
  logic [31:0]     rd_word_q;
  logic            rd_vld_q;
  logic            rd_en;
  logic            rd_pend_q;
  logic [FW-1:0]   fill_q;
  logic [15:0]     count_q, count_d;
  logic [15:0]     lim_q, lim_d;
  logic [31:0]     off_q;
  logic            done_q;
  logic [31:0]     faddr_q;
  logic [1:0]      status_q;

  logic [31:0]     word_eff;
  logic [31:0]     free_idx;
  logic [WA_W-1:0] free_word;
  logic [4:0]      free_bit;
  logic [4:0]      hit_bit;
  logic [31:0]     hit_idx;
  logic [31:0]     word_base;
  logic [31:0]     alloc_addr;
  logic            wr_en;
  logic [31:0]     wr_word;

  // frames past the bitmap never count
  assign lim_d = (32'(cfg_i.frame_count) > 32'(FRAMES)) ? 16'(FRAMES) : cfg_i.frame_count;

  // words at or above the fill mark were never written and read as all free
  assign word_eff  = rd_vld_q ? rd_word_q : 32'd0;

  assign free_idx  = off_q >> PAGE_SHIFT;
  assign free_word = free_idx[WA_W+4:5];
  assign free_bit  = free_idx[4:0];

  assign hit_bit    = bfa_pkg::first_zero(word_eff);
  assign word_base  = 32'(rd_addr_q) << 5;
  assign hit_idx    = word_base | 32'(hit_bit);
  assign alloc_addr = cfg_i.base_address + 32'(hit_idx << PAGE_SHIFT);

  assign rd_en   = cmd_i.scan_rd || cmd_i.free_rd;
  assign rd_addr = cmd_i.scan_rd ? scan_addr_q : free_word;
  assign wr_en   = cmd_i.alloc_commit || cmd_i.free_commit;
  assign wr_word = cmd_i.alloc_commit ? (word_eff | (32'd1 << hit_bit))
                                      : (word_eff & ~(32'd1 << free_bit));

  assign scan_addr_d = cmd_i.scan_start ? '0 :
                       (scan_addr_q == LastWord) ? scan_addr_q : scan_addr_q + WA_W'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.alloc_commit) count_d = count_q + 16'd1;
    else if (cmd_i.free_commit) count_d = count_q - 16'd1;
  end

  assign stat_o.free_in_range = free_idx < 32'(lim_q);
  assign stat_o.free_bit_set  = word_eff[free_bit];
  assign stat_o.word_ready    = rd_pend_q;
  assign stat_o.word_has_free = ~word_eff != 32'd0;
  assign stat_o.word_past_lim = word_base >= 32'(lim_q);
  assign stat_o.word_last     = rd_addr_q == LastWord;
  assign stat_o.hit_in_range  = hit_idx < 32'(lim_q);

  // bitmap memory, one port read and one write, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[rd_addr_q] <= wr_word;
    if (rd_en) begin
      rd_word_q <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      rd_vld_q  <= FW'(rd_addr) < fill_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_free) off_q <= free_address_i - cfg_i.base_address;
    if (cmd_i.scan_start || cmd_i.scan_rd) scan_addr_q <= scan_addr_d;
    if (cmd_i.fin) begin
      faddr_q  <= cmd_i.alloc_commit ? alloc_addr : 32'd0;
      status_q <= cmd_i.fin_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      fill_q    <= '0;
      count_q   <= 16'd0;
      lim_q     <= 16'd0;
      done_q    <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_rd;
      if (wr_en && (FW'(rd_addr_q) == fill_q)) fill_q <= fill_q + FW'(1);
      count_q   <= count_d;
      lim_q     <= lim_d;
      done_q    <= cmd_i.fin;
    end
  end

  assign done_o          = done_q;
  assign frame_address_o = faddr_q;
  assign status_o        = status_q;
  assign frames_in_use_o = count_q;

endmodule

`default_nettype wire

### design/bfa_checker.sv
// port level checks of the frame allocator and their binding
`default_nettype none

module bfa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [31:0] frame_address_o,
  input wire logic [1:0]  status_o,
  input wire logic [15:0] frames_in_use_o
);

  // an accepted transaction always leaves the block busy once it is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // the result strobe comes as the block returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a failed request never hands out an address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bfa_pkg::ST_OK) |-> (frame_address_o == 32'd0))
    else $error("nonzero address on failed request");

  // the used count only moves together with a result
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(frames_in_use_o) |-> done_o)
    else $error("used count changed without a result");

endmodule

bind bitmap_frame_allocator_top bfa_checker u_bfa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .done_o          (done_o),
  .frame_address_o (frame_address_o),
  .status_o        (status_o),
  .frames_in_use_o (frames_in_use_o)
);

`default_nettype wire
